FILE: hdl/spt_pkg.sv
// ----------------------------------------------------------------------------
// Solenoid pulse timer bank package
// Shared types, command codes and register constants for the timer bank.
// ----------------------------------------------------------------------------
package spt_pkg;

   // Defaults for the top-level parameters.
   localparam int CHANNELS_DEF   = 4;
   localparam int TICK_WIDTH_DEF = 16;

   // Configuration register file.
   localparam int REG_W      = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_STRIKE_TICKS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ON_TICKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_OFF_TICKS = 2'd2;

   localparam logic [REG_W-1:0] STRIKE_TICKS_RST  = 16'd50;
   localparam logic [REG_W-1:0] MAX_ON_TICKS_RST  = 16'd100;
   localparam logic [REG_W-1:0] MIN_OFF_TICKS_RST = 16'd100;

   // Word field widths.
   localparam int CMD_W    = 3;
   localparam int FINGER_W = 4;
   localparam int MASK_W   = 4;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_STRIKE      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE_ALL = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TICK_ONE    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TICK_ALL    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_QUERY       = 3'd5;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [FINGER_W-1:0] finger;
   } req_word_type;

   typedef struct packed {
      logic              ok;
      logic [MASK_W-1:0] drive_mask;
      logic [MASK_W-1:0] idle_mask;
   } rsp_word_type;

   // Per-channel control for one processed word (at most one bit set).
   typedef struct packed {
      logic strike;
      logic drop;
      logic tick;
   } chan_ctl_type;

   // Per-channel status.
   typedef struct packed {
      logic active;
      logic idle;
   } chan_stat_type;

endpackage

FILE: hdl/spt_channel.sv
// ----------------------------------------------------------------------------
// Solenoid pulse timer channel
// Mode and tick counter of one channel, updated by strike, drop and tick.
// ----------------------------------------------------------------------------
module spt_channel
   import spt_pkg::*;
#(
   parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  chan_ctl_type     ctl,
   input  logic [REG_W-1:0] on_limit,
   input  logic [REG_W-1:0] off_limit,
   output chan_stat_type    stat_now,
   output chan_stat_type    stat_next
);

   localparam int CMP_W = (TICK_WIDTH > REG_W) ? TICK_WIDTH : REG_W;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_ACTIVE,
      MODE_COOL
   } mode_type;

   mode_type              mode_ff, mode_in;
   logic [TICK_WIDTH-1:0] ticks_ff, ticks_in;
   logic [TICK_WIDTH-1:0] ticks_inc;

   // The counter saturates at its all-ones value.
   assign ticks_inc = (&ticks_ff) ? ticks_ff : ticks_ff + 1'b1;

   always_comb begin
      mode_in  = mode_ff;
      ticks_in = ticks_ff;
      if (ctl.strike) begin
         if (mode_ff == MODE_IDLE) begin
            mode_in  = MODE_ACTIVE;
            ticks_in = '0;
         end
      end else if (ctl.drop) begin
         mode_in  = MODE_COOL;
         ticks_in = '0;
      end else if (ctl.tick) begin
         case (mode_ff)
            MODE_ACTIVE: begin
               if (CMP_W'(ticks_inc) >= CMP_W'(on_limit)) begin
                  mode_in  = MODE_COOL;
                  ticks_in = '0;
               end else begin
                  ticks_in = ticks_inc;
               end
            end
            MODE_COOL: begin
               ticks_in = ticks_inc;
               if (CMP_W'(ticks_inc) >= CMP_W'(off_limit)) begin
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               mode_in  = mode_ff;
               ticks_in = ticks_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         ticks_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         ticks_ff <= ticks_in;
      end
   end

   assign stat_now.active  = (mode_ff == MODE_ACTIVE);
   assign stat_now.idle    = (mode_ff == MODE_IDLE);
   assign stat_next.active = (mode_in == MODE_ACTIVE);
   assign stat_next.idle   = (mode_in == MODE_IDLE);

endmodule

FILE: hdl/solenoid_pulse_timer_bank.sv
// ----------------------------------------------------------------------------
// Solenoid pulse timer bank
// Bank of solenoid channels with strike, release, tick and query commands.
// ----------------------------------------------------------------------------
// Every command word produces exactly one response word. The block takes one
// word per clock cycle while req_stall is low; a word lands in an input
// register, then the channel states are updated from it and the response is
// captured in a result register once that register is free. The rate is set
// by the per-channel update, which is a single increment and compare per
// channel.
// While a response waits, one more command word can be taken into the input
// register; req_stall rises only when both registers are full and the result
// is held by rsp_stall. The limit registers are written through the csr_
// port, which the user must do only while no command is in flight; the block
// itself does not enforce this. Writes to an index beyond the three
// registers are ignored. The masks report channels zero to three.
module solenoid_pulse_timer_bank
   import spt_pkg::*;
#(
   parameter int CHANNELS   = CHANNELS_DEF,
   parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_word_type         req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_word_type         rsp_word,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   // Configuration registers.
   logic [REG_W-1:0] strike_ticks_ff;
   logic [REG_W-1:0] max_on_ticks_ff;
   logic [REG_W-1:0] min_off_ticks_ff;
   logic [REG_W-1:0] on_limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         strike_ticks_ff  <= STRIKE_TICKS_RST;
         max_on_ticks_ff  <= MAX_ON_TICKS_RST;
         min_off_ticks_ff <= MIN_OFF_TICKS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_STRIKE_TICKS:  strike_ticks_ff  <= csr_wdata;
            CSR_MAX_ON_TICKS:  max_on_ticks_ff  <= csr_wdata;
            CSR_MIN_OFF_TICKS: min_off_ticks_ff <= csr_wdata;
            default: begin
               strike_ticks_ff <= strike_ticks_ff;
            end
         endcase
      end
   end

   // The active phase ends at the lesser of the strike and safety limits.
   assign on_limit = (strike_ticks_ff < max_on_ticks_ff) ? strike_ticks_ff
                                                         : max_on_ticks_ff;

   // Handshake: an input register and a result register.
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         out_free;
   logic         process;
   logic         load_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign load_in   = req_valid && !req_stall;

   always_comb begin
      if (load_in) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (process) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         in_word_ff <= req_word;
      end
      if (process) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // Channel decode: a finger at or above the channel count selects nothing,
   // so single-channel commands with such a finger fall through without effect.
   chan_ctl_type  ctl       [CHANNELS];
   chan_stat_type stat_now  [CHANNELS];
   chan_stat_type stat_next [CHANNELS];
   logic [CHANNELS-1:0] sel;
   logic [CHANNELS-1:0] now_idle;

   for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
      assign sel[i]      = (in_word_ff.finger == FINGER_W'(i));
      assign now_idle[i] = stat_now[i].idle;

      always_comb begin
         ctl[i] = '0;
         if (process) begin
            case (in_word_ff.cmd)
               CMD_STRIKE:      ctl[i].strike = sel[i];
               CMD_RELEASE:     ctl[i].drop   = sel[i];
               CMD_RELEASE_ALL: ctl[i].drop   = 1'b1;
               CMD_TICK_ONE:    ctl[i].tick   = sel[i];
               CMD_TICK_ALL:    ctl[i].tick   = 1'b1;
               default:         ctl[i]        = '0;
            endcase
         end
      end

      spt_channel #(
         .TICK_WIDTH (TICK_WIDTH)
      ) u_channel (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl[i]),
         .on_limit  (on_limit),
         .off_limit (min_off_ticks_ff),
         .stat_now  (stat_now[i]),
         .stat_next (stat_next[i])
      );
   end

   // Response: ok reflects the selected channel being idle before the
   // command, for a strike or a query; the masks show the state after it.
   assign rsp_word_in.ok = (in_word_ff.cmd inside {CMD_STRIKE, CMD_QUERY})
                           && (|(sel & now_idle));

   for (genvar j = 0; j < MASK_W; j++) begin : g_mask
      if (j < CHANNELS) begin : g_used
         assign rsp_word_in.drive_mask[j] = stat_next[j].active;
         assign rsp_word_in.idle_mask[j]  = stat_next[j].idle;
      end else begin : g_unused
         assign rsp_word_in.drive_mask[j] = 1'b0;
         assign rsp_word_in.idle_mask[j]  = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
